// ----- sv/cfl_pkg.sv -----
// ----------------------------------------------------------------------------
// cfl_pkg
// Shared types, codes and arithmetic helpers for the path command flattener.
// ----------------------------------------------------------------------------
package cfl_pkg;

  localparam int COORD_W         = 32;
  localparam int CURVE_STEPS_DEF = 20;

  typedef enum logic [3:0] {
    CMD_MREL  = 4'd0,
    CMD_MABS  = 4'd1,
    CMD_CREL  = 4'd2,
    CMD_CABS  = 4'd3,
    CMD_VREL  = 4'd4,
    CMD_VABS  = 4'd5,
    CMD_HREL  = 4'd6,
    CMD_HABS  = 4'd7,
    CMD_LREL  = 4'd8,
    CMD_CLOSE = 4'd9,
    CMD_UNSUP = 4'd10
  } cmd_code_t;

  typedef struct packed {
    logic [3:0]                command;
    logic                      starts_command;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
  } cmd_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      new_path;
    logic                      last;
  } pt_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MAC,
    ST_DIV_LOAD,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic simple_emit;
    logic curve_init;
    logic mac_step;
    logic div_load;
    logic div_step;
    logic curve_emit;
  } ctl_t;

  typedef struct packed {
    logic item_skip;
    logic item_curve;
    logic mac_last;
    logic div_last;
    logic k_last;
    logic out_free;
  } sts_t;

  function automatic logic signed [COORD_W-1:0] sat33(input logic signed [COORD_W:0] v);
    logic signed [COORD_W-1:0] r;
    if (v[COORD_W] != v[COORD_W-1]) begin
      r = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_add(input logic signed [COORD_W-1:0] a,
                                                        input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    return sat33(s);
  endfunction

  // elaboration-time bernstein weight C(3,i) k^i (n-k)^(3-i)
  function automatic int bern_weight(input int n, input int k, input int i);
    int m;
    int w;
    m = n - k;
    case (i)
      0:       w = m * m * m;
      1:       w = 3 * k * m * m;
      2:       w = 3 * k * k * m;
      default: w = k * k * k;
    endcase
    return w;
  endfunction

endpackage

// ----- sv/cfl_div.sv -----
// ----------------------------------------------------------------------------
// cfl_div
// Divider by a fixed denominator: reciprocal multiply on split halves of the
// numerator, sum of the halves, multiply back, then one correction compare.
// ----------------------------------------------------------------------------
module cfl_div #(
  parameter int DEN = 8000,
  parameter int DW  = 13,
  parameter int QW  = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             step,
  input  logic [QW+DW-1:0] num,
  output logic [QW-1:0]    quo,
  output logic             last
);

  localparam int UW = QW + DW;
  localparam int LW = UW / 2;
  localparam int HW = UW - LW;
  localparam int MW = QW + 2;
  localparam int SW = HW + MW + 1;
  localparam logic [MW-1:0] RECIP     = MW'((64'd1 << UW) / 64'(DEN));
  localparam logic [1:0]    LAST_STEP = 2'd3;

  logic [UW-1:0]    n;
  logic [LW+MW-1:0] prod_lo;
  logic [HW+MW-1:0] prod_hi;
  logic [SW-1:0]    sum_hi;
  logic [QW:0]      q_est;
  logic [UW-1:0]    q_den;
  logic [UW-1:0]    rem;
  logic             ge;
  logic [QW-1:0]    q;
  logic [1:0]       cnt;
  logic             busy;

  // estimate is the true quotient or one below it
  assign sum_hi = SW'(prod_hi) + SW'(prod_lo[LW+MW-1:LW]);
  assign rem    = n - q_den;
  assign ge     = (rem >= UW'(DEN));
  assign quo    = q;
  assign last   = busy && (cnt == LAST_STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (step && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      n   <= num;
      cnt <= '0;
    end else if (step && busy) begin
      case (cnt)
        2'd0: begin
          prod_lo <= n[LW-1:0] * RECIP;
          prod_hi <= n[UW-1:LW] * RECIP;
        end
        2'd1:    q_est <= sum_hi[HW+QW:HW];
        2'd2:    q_den <= UW'(q_est) * UW'(DEN);
        default: q     <= q_est[QW-1:0] + QW'(ge);
      endcase
      cnt <= cnt + 2'd1;
    end
  end

endmodule

// ----- sv/cfl_dp.sv -----
// ----------------------------------------------------------------------------
// cfl_dp
// Datapath: current and subpath points, curve control points, bernstein
// multiply-accumulate, rounding divide and the output register.
// ----------------------------------------------------------------------------
module cfl_dp import cfl_pkg::*; #(
  parameter int N = CURVE_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  ctl_t      ctl,
  output sts_t      sts,
  input  cmd_item_t cmd_data,
  output logic      pt_valid,
  input  logic      pt_ready,
  output pt_item_t  pt_data
);

  localparam int DEN  = N * N * N;
  localparam int DW   = $clog2(DEN + 1);
  localparam int AW   = COORD_W + DW + 1;
  localparam int KW   = $clog2(N + 1);
  localparam int HALF = DEN / 2;
  localparam logic [2:0] MAC_LAST = 3'd4;

  cmd_item_t item;
  logic signed [COORD_W-1:0] cur_x, cur_y, start_x, start_y;
  logic signed [COORD_W-1:0] cpx [4];
  logic signed [COORD_W-1:0] cpy [4];
  logic [KW-1:0]  k;
  logic [2:0]     mac_j;
  logic signed [AW-1:0] prod_x, prod_y, acc_x, acc_y;
  logic           neg_x, neg_y;
  pt_item_t       out_q;
  logic           out_valid;

  logic [3:0][DW-1:0] wtab [N+1];
  logic [DW-1:0]      wsel;
  logic signed [COORD_W-1:0] nx, ny, c1x, c1y, c2x, c2y, c3x, c3y;
  logic           is_move, is_curve, is_skip, is_rel;
  logic [AW-1:0]  u_x, u_y;
  logic [COORD_W-1:0] qx, qy;
  logic           div_last_x, div_last_y;
  logic signed [COORD_W:0] rnd_x, rnd_y;

  // bernstein weight table
  for (genvar gk = 0; gk <= N; gk++) begin : g_wk
    for (genvar gi = 0; gi < 4; gi++) begin : g_wi
      assign wtab[gk][gi] = DW'(bern_weight(N, gk, gi));
    end
  end

  assign wsel = wtab[k][mac_j[1:0]];

  always_comb begin
    is_move  = 1'b0;
    is_curve = 1'b0;
    is_skip  = 1'b0;
    nx = cur_x;
    ny = cur_y;
    case (item.command)
      CMD_MREL: begin
        is_move = 1'b1;
        nx = sat_add(cur_x, item.ax);
        ny = sat_add(cur_y, item.ay);
      end
      CMD_MABS: begin
        is_move = 1'b1;
        nx = item.ax;
        ny = item.ay;
      end
      CMD_CREL, CMD_CABS: is_curve = 1'b1;
      CMD_VREL:  ny = sat_add(cur_y, item.ax);
      CMD_VABS:  ny = item.ax;
      CMD_HREL:  nx = sat_add(cur_x, item.ax);
      CMD_HABS:  nx = item.ax;
      CMD_LREL: begin
        nx = sat_add(cur_x, item.ax);
        ny = sat_add(cur_y, item.ay);
      end
      CMD_CLOSE: begin
        nx = start_x;
        ny = start_y;
      end
      default: is_skip = 1'b1;
    endcase
  end

  assign is_rel = (item.command == CMD_CREL);
  assign c1x = is_rel ? sat_add(cur_x, item.ax) : item.ax;
  assign c1y = is_rel ? sat_add(cur_y, item.ay) : item.ay;
  assign c2x = is_rel ? sat_add(cur_x, item.bx) : item.bx;
  assign c2y = is_rel ? sat_add(cur_y, item.by) : item.by;
  assign c3x = is_rel ? sat_add(cur_x, item.ex) : item.ex;
  assign c3y = is_rel ? sat_add(cur_y, item.ey) : item.ey;

  // magnitude plus half for round to nearest, ties away from zero
  assign u_x = acc_x[AW-1] ? (AW'(HALF) - acc_x) : (acc_x + AW'(HALF));
  assign u_y = acc_y[AW-1] ? (AW'(HALF) - acc_y) : (acc_y + AW'(HALF));

  cfl_div #(.DEN(DEN), .DW(DW), .QW(COORD_W)) u_div_x (
    .clk  (clk),
    .rst  (rst),
    .load (ctl.div_load),
    .step (ctl.div_step),
    .num  (u_x[COORD_W+DW-1:0]),
    .quo  (qx),
    .last (div_last_x)
  );

  cfl_div #(.DEN(DEN), .DW(DW), .QW(COORD_W)) u_div_y (
    .clk  (clk),
    .rst  (rst),
    .load (ctl.div_load),
    .step (ctl.div_step),
    .num  (u_y[COORD_W+DW-1:0]),
    .quo  (qy),
    .last (div_last_y)
  );

  assign rnd_x = neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign rnd_y = neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

  always_comb begin
    sts.item_skip  = is_skip;
    sts.item_curve = is_curve;
    sts.mac_last   = (mac_j == MAC_LAST);
    sts.div_last   = div_last_x && div_last_y;
    sts.k_last     = (k == KW'(N));
    sts.out_free   = !out_valid || pt_ready;
  end

  // control state and point registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x     <= '0;
      cur_y     <= '0;
      start_x   <= '0;
      start_y   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.simple_emit) begin
        cur_x <= nx;
        cur_y <= ny;
        if (is_move) begin
          start_x <= nx;
          start_y <= ny;
        end
      end
      if (ctl.curve_init) begin
        cur_x <= c3x;
        cur_y <= c3y;
      end
      if (ctl.simple_emit || ctl.curve_emit) begin
        out_valid <= 1'b1;
      end else if (pt_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item <= cmd_data;
    end
    if (ctl.curve_init) begin
      cpx[0] <= cur_x;
      cpy[0] <= cur_y;
      cpx[1] <= c1x;
      cpy[1] <= c1y;
      cpx[2] <= c2x;
      cpy[2] <= c2y;
      cpx[3] <= c3x;
      cpy[3] <= c3y;
      k      <= KW'(1);
      mac_j  <= '0;
    end
    if (ctl.mac_step) begin
      mac_j <= mac_j + 3'd1;
      if (mac_j != MAC_LAST) begin
        prod_x <= $signed({1'b0, wsel}) * cpx[mac_j[1:0]];
        prod_y <= $signed({1'b0, wsel}) * cpy[mac_j[1:0]];
      end
      acc_x <= (mac_j == 3'd0) ? '0 : acc_x + prod_x;
      acc_y <= (mac_j == 3'd0) ? '0 : acc_y + prod_y;
    end
    if (ctl.div_load) begin
      neg_x <= acc_x[AW-1];
      neg_y <= acc_y[AW-1];
    end
    if (ctl.curve_emit) begin
      k     <= k + KW'(1);
      mac_j <= '0;
    end
    if (ctl.simple_emit) begin
      out_q.px       <= nx;
      out_q.py       <= ny;
      out_q.new_path <= is_move && item.starts_command;
      out_q.last     <= 1'b1;
    end else if (ctl.curve_emit) begin
      out_q.px       <= sat33(rnd_x);
      out_q.py       <= sat33(rnd_y);
      out_q.new_path <= 1'b0;
      out_q.last     <= (k == KW'(N));
    end
  end

  assign pt_valid = out_valid;
  assign pt_data  = out_q;

endmodule

// ----- sv/cfl_ctrl.sv -----
// ----------------------------------------------------------------------------
// cfl_ctrl
// Controller: sequences command dispatch, per-point multiply-accumulate,
// divide and emit.
// ----------------------------------------------------------------------------
module cfl_ctrl import cfl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    cmd_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctl.load_item = 1'b1;
          state_next    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.item_skip) begin
          state_next = ST_IDLE;
        end else if (sts.item_curve) begin
          ctl.curve_init = 1'b1;
          state_next     = ST_MAC;
        end else if (sts.out_free) begin
          ctl.simple_emit = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_MAC: begin
        ctl.mac_step = 1'b1;
        if (sts.mac_last) begin
          state_next = ST_DIV_LOAD;
        end
      end
      ST_DIV_LOAD: begin
        ctl.div_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          ctl.curve_emit = 1'b1;
          state_next     = sts.k_last ? ST_IDLE : ST_MAC;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- sv/path_command_flattener.sv -----
// ----------------------------------------------------------------------------
// path_command_flattener
// Applies tokenized path commands to the current point and flattens cubic
// curves into CURVE_STEPS points with bernstein weights and rounding.
// ----------------------------------------------------------------------------
//  channel  valid      ready      payload               transfer
//  command  cmd_valid  cmd_ready  cmd_data (cmd_item_t)  one path command
//  point    pt_valid   pt_ready   pt_data  (pt_item_t)   one emitted point
//
//  move, line, close and unsupported commands: a dispatch after acceptance
//  cubic curve: a dispatch, then for each of the CURVE_STEPS points a
//  multiply-accumulate phase, a divider load, a reciprocal divide phase
//  and an emit
//  reset clears the current and subpath points to zero and empties the output
//  a stalled point holds the block until the output register frees up
// ----------------------------------------------------------------------------
module path_command_flattener import cfl_pkg::*; #(
  parameter int CURVE_STEPS = CURVE_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_item_t cmd_data,
  output logic      pt_valid,
  input  logic      pt_ready,
  output pt_item_t  pt_data
);

  ctl_t ctl;
  sts_t sts;

  cfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  cfl_dp #(.N(CURVE_STEPS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sts      (sts),
    .cmd_data (cmd_data),
    .pt_valid (pt_valid),
    .pt_ready (pt_ready),
    .pt_data  (pt_data)
  );

`ifndef ASSERT_OFF
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command accepted while previous command still in flight");

  a_new_path_last: assert property (@(posedge clk) disable iff (rst)
    pt_valid && pt_data.new_path |-> pt_data.last)
    else $error("new path point is not the last point of its command");

  a_div_last_step: assert property (@(posedge clk) disable iff (rst)
    sts.div_last |-> ctl.div_step)
    else $error("divider finished outside the divide phase");
`endif

endmodule
